// ----- src/plq_pkg.sv -----
package plq_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int QTY_IN_W   = 32;
  localparam int QTY_BITS   = 32;
  localparam int VOL_W      = 38;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [QTY_BITS-1:0] qty_t;
  typedef logic [VOL_W-1:0]    vol_t;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_MOVE   = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NO_MOVE  = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]          req_type;
    slot_t               slot;
    logic [QTY_IN_W-1:0] quantity;
  } plq_req_t;

  typedef struct packed {
    logic [1:0] status;
    slot_t      head_slot;
    slot_t      tail_slot;
    cnt_t       count;
    vol_t       total_volume;
  } plq_rsp_t;

  // Two write ports into one link table; port 1 wins on an address clash.
  typedef struct packed {
    logic  w0_en;
    slot_t w0_addr;
    slot_t w0_data;
    logic  w1_en;
    slot_t w1_addr;
    slot_t w1_data;
  } plq_link_wr_t;

endpackage

// ----- src/plq_link_mem.sv -----
module plq_link_mem
  import plq_pkg::*;
(
  input  logic         clk,
  input  logic         rd_en,
  input  slot_t        rd_addr,
  input  plq_link_wr_t wr,
  output slot_t        rd_data
);

  // Two single-write banks; sel_bits records which bank holds the latest value.
  slot_t bank0 [POOL_SLOTS];
  slot_t bank1 [POOL_SLOTS];
  logic  sel_bits [POOL_SLOTS];

  slot_t b0_r;
  slot_t b1_r;
  slot_t byp_data_r;
  logic  sel_r;
  logic  byp_r;
  logic  hit0;
  logic  hit1;

  assign hit0 = wr.w0_en && (wr.w0_addr == rd_addr);
  assign hit1 = wr.w1_en && (wr.w1_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.w0_en) begin
      bank0[wr.w0_addr]    <= wr.w0_data;
      sel_bits[wr.w0_addr] <= 1'b0;
    end
    if (wr.w1_en) begin
      bank1[wr.w1_addr]    <= wr.w1_data;
      sel_bits[wr.w1_addr] <= 1'b1;
    end
  end

  // Forward a write landing on the same edge as the read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      b0_r       <= bank0[rd_addr];
      b1_r       <= bank1[rd_addr];
      sel_r      <= sel_bits[rd_addr];
      byp_r      <= hit0 || hit1;
      byp_data_r <= hit1 ? wr.w1_data : wr.w0_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : (sel_r ? b1_r : b0_r);

endmodule

// ----- src/price_level_order_queue.sv -----
// A request accepted into a_req_r shows its result at out_ as it leaves the
// decision stage, where the link tables, read in the accept cycle, are updated
// with forwarding. Throughput: one request per cycle unless out_stall stalls.
// Reset (rst_n low, synchronous): head, tail, count, volume and all valid flags
// clear; link and quantity tables keep their contents and are not swept.
module price_level_order_queue
  import plq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  plq_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output plq_rsp_t out_data
);

  logic         in_acc;
  logic         a_go;
  logic         a_vld_r;
  plq_req_t     a_req_r;
  logic         out_vld_r;
  plq_rsp_t     out_data_r;

  slot_t        head_r;
  slot_t        tail_r;
  cnt_t         cnt_r;
  vol_t         vol_r;
  slot_t        head_nxt;
  slot_t        tail_nxt;
  cnt_t         cnt_nxt;
  vol_t         vol_nxt;
  status_code_t status;
  plq_rsp_t     rsp;

  plq_link_wr_t next_wr;
  plq_link_wr_t prev_wr;
  slot_t        nx_rd;
  slot_t        pv_rd;

  qty_t         qty_mem [POOL_SLOTS];
  qty_t         q_mem_r;
  qty_t         q_byp_r;
  logic         q_hit_r;
  logic         q_we;
  qty_t         q_rd;
  qty_t         a_qty;
  slot_t        s;

  assign a_go     = a_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = a_vld_r && !a_go;
  assign in_acc   = in_valid && !in_stall;

  assign s     = a_req_r.slot;
  assign a_qty = a_req_r.quantity[QTY_BITS-1:0];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    vol_nxt  = vol_r;
    status   = ST_OK;
    q_we     = 1'b0;
    next_wr  = '0;
    prev_wr  = '0;
    case (a_req_r.req_type)
      REQ_APPEND: begin
        if (cnt_r == CNT_W'(POOL_SLOTS)) begin
          status = ST_FULL;
        end else begin
          q_we = 1'b1;
          if (cnt_r == '0) begin
            head_nxt = s;
          end else begin
            prev_wr.w1_en   = 1'b1;
            prev_wr.w1_addr = s;
            prev_wr.w1_data = tail_r;
            next_wr.w1_en   = 1'b1;
            next_wr.w1_addr = tail_r;
            next_wr.w1_data = s;
          end
          tail_nxt = s;
          cnt_nxt  = cnt_r + 1'b1;
          vol_nxt  = vol_r + VOL_W'(a_qty);
        end
      end
      REQ_REMOVE: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end else begin
          vol_nxt = vol_r - VOL_W'(q_rd);
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r != CNT_W'(1)) begin
            if (s == head_r) begin
              head_nxt = nx_rd;
            end else if (s == tail_r) begin
              tail_nxt = pv_rd;
            end else begin
              // unlink from the middle
              prev_wr.w0_en   = 1'b1;
              prev_wr.w0_addr = nx_rd;
              prev_wr.w0_data = pv_rd;
              next_wr.w0_en   = 1'b1;
              next_wr.w0_addr = pv_rd;
              next_wr.w0_data = nx_rd;
            end
          end
        end
      end
      REQ_MOVE: begin
        if (cnt_r <= CNT_W'(1) || s == tail_r) begin
          status = ST_NO_MOVE;
        end else begin
          if (s == head_r) begin
            head_nxt = nx_rd;
          end else begin
            next_wr.w0_en   = 1'b1;
            next_wr.w0_addr = pv_rd;
            next_wr.w0_data = nx_rd;
            prev_wr.w0_en   = 1'b1;
            prev_wr.w0_addr = nx_rd;
            prev_wr.w0_data = pv_rd;
          end
          prev_wr.w1_en   = 1'b1;
          prev_wr.w1_addr = s;
          prev_wr.w1_data = tail_r;
          next_wr.w1_en   = 1'b1;
          next_wr.w1_addr = tail_r;
          next_wr.w1_data = s;
          tail_nxt = s;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    // only commit when the request actually leaves the stage
    if (!a_go) begin
      q_we    = 1'b0;
      next_wr = '0;
      prev_wr = '0;
    end
  end

  always_comb begin
    rsp.status       = status;
    rsp.head_slot    = (cnt_nxt != '0) ? head_nxt : '0;
    rsp.tail_slot    = (cnt_nxt != '0) ? tail_nxt : '0;
    rsp.count        = cnt_nxt;
    rsp.total_volume = vol_nxt;
  end

  plq_link_mem u_next_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_data.slot),
    .wr      (next_wr),
    .rd_data (nx_rd)
  );

  plq_link_mem u_prev_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_data.slot),
    .wr      (prev_wr),
    .rd_data (pv_rd)
  );

  always_ff @(posedge clk) begin
    if (q_we) begin
      qty_mem[s] <= a_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_mem_r <= qty_mem[in_data.slot];
      q_hit_r <= q_we && (s == in_data.slot);
      q_byp_r <= a_qty;
    end
  end

  assign q_rd = q_hit_r ? q_byp_r : q_mem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      vol_r     <= '0;
    end else begin
      if (in_acc) begin
        a_vld_r <= 1'b1;
      end else if (a_go) begin
        a_vld_r <= 1'b0;
      end
      if (a_go) begin
        out_vld_r <= 1'b1;
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        cnt_r     <= cnt_nxt;
        vol_r     <= vol_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_req_r <= in_data;
    end
    if (a_go) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/plq_checker.sv -----
module plq_checker
  import plq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input plq_req_t in_data,
  input logic     out_valid,
  input logic     out_stall,
  input plq_rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.count == CNT_W'(POOL_SLOTS))
    else $error("pool full reported with free slots");

  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0)
    else $error("list empty reported with listed entries");

  a_zero_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.count == '0 |->
      out_data.head_slot == '0 && out_data.tail_slot == '0)
    else $error("empty list shows nonzero head or tail");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

endmodule

bind price_level_order_queue plq_checker u_plq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/tb_top.sv -----
module tb_top;
  import plq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 11;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  plq_req_t in_data;
  logic     out_valid;
  logic     out_stall;
  plq_rsp_t out_data;

  bit calm;
  int err_cnt;
  plq_rsp_t level_rsp_q[$];

  // Shadow of the price level: link tables, quantities and list summary.
  bit [SLOT_W-1:0]   nxt_tbl [POOL_SLOTS];
  bit [SLOT_W-1:0]   prv_tbl [POOL_SLOTS];
  bit [QTY_BITS-1:0] qty_tbl [POOL_SLOTS];
  bit                nxt_set [POOL_SLOTS];
  bit                prv_set [POOL_SLOTS];
  bit                qty_set [POOL_SLOTS];
  bit [SLOT_W-1:0]   head_q;
  bit [SLOT_W-1:0]   tail_q;
  bit [CNT_W-1:0]    live_cnt;
  bit [VOL_W-1:0]    vol_acc;

  price_level_order_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

  // Apply one request to the shadow list and return the response it expects.
  function automatic plq_rsp_t level_step(plq_req_t r);
    bit [SLOT_W-1:0] s;
    bit [SLOT_W-1:0] nx;
    bit [SLOT_W-1:0] pv;
    plq_rsp_t rsp;
    s = r.slot;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_APPEND: begin
        if (live_cnt == POOL_SLOTS) begin
          rsp.status = ST_FULL;
        end else begin
          qty_tbl[s] = r.quantity[QTY_BITS-1:0];
          qty_set[s] = 1'b1;
          if (live_cnt == 0) begin
            head_q = s;
            tail_q = s;
          end else begin
            prv_tbl[s] = tail_q;
            prv_set[s] = 1'b1;
            nxt_tbl[tail_q] = s;
            nxt_set[tail_q] = 1'b1;
            tail_q = s;
          end
          live_cnt = live_cnt + 1'b1;
          vol_acc = vol_acc + qty_tbl[s];
        end
      end
      REQ_REMOVE: begin
        if (live_cnt == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          vol_acc = vol_acc - qty_tbl[s];
          live_cnt = live_cnt - 1'b1;
          // the last entry leaves its links untouched
          if (live_cnt != 0) begin
            nx = nxt_tbl[s];
            pv = prv_tbl[s];
            if (s == head_q) begin
              head_q = nx;
            end else if (s == tail_q) begin
              tail_q = pv;
            end else begin
              prv_tbl[nx] = pv;
              prv_set[nx] = 1'b1;
              nxt_tbl[pv] = nx;
              nxt_set[pv] = 1'b1;
            end
          end
        end
      end
      REQ_MOVE: begin
        if (live_cnt <= 1 || s == tail_q) begin
          rsp.status = ST_NO_MOVE;
        end else begin
          nx = nxt_tbl[s];
          pv = prv_tbl[s];
          if (s == head_q) begin
            head_q = nx;
          end else begin
            nxt_tbl[pv] = nx;
            nxt_set[pv] = 1'b1;
            prv_tbl[nx] = pv;
            prv_set[nx] = 1'b1;
          end
          prv_tbl[s] = tail_q;
          prv_set[s] = 1'b1;
          nxt_tbl[tail_q] = s;
          nxt_set[tail_q] = 1'b1;
          tail_q = s;
        end
      end
      default: ;
    endcase
    rsp.head_slot    = (live_cnt != 0) ? head_q : '0;
    rsp.tail_slot    = (live_cnt != 0) ? tail_q : '0;
    rsp.count        = live_cnt;
    rsp.total_volume = vol_acc;
    return rsp;
  endfunction

  // True when every table entry whose value decides the result has been written.
  function automatic bit reads_defined(plq_req_t r);
    bit [SLOT_W-1:0] s;
    s = r.slot;
    case (r.req_type)
      REQ_REMOVE: begin
        if (live_cnt == 0) return 1'b1;
        if (!qty_set[s]) return 1'b0;
        if (live_cnt == 1) return 1'b1;
        if (s == head_q) return nxt_set[s];
        if (s == tail_q) return prv_set[s];
        return nxt_set[s] && prv_set[s];
      end
      REQ_MOVE: begin
        if (live_cnt <= 1 || s == tail_q) return 1'b1;
        if (s == head_q) return nxt_set[s];
        return nxt_set[s] && prv_set[s];
      end
      default: return 1'b1;
    endcase
  endfunction

  // Pick a listed slot, leaning toward the head and the tail.
  function automatic int unsigned pick_listed();
    bit [SLOT_W-1:0] walk;
    int unsigned k;
    int unsigned hop;
    k = $urandom_range(99);
    if (k < 25) return head_q;
    if (k < 45) return tail_q;
    hop = $urandom_range(int'(live_cnt) - 1);
    walk = head_q;
    repeat (hop) walk = nxt_tbl[walk];
    return walk;
  endfunction

  function automatic int unsigned pick_free();
    bit taken [POOL_SLOTS];
    bit [SLOT_W-1:0] walk;
    int unsigned s;
    walk = head_q;
    for (int i = 0; i < live_cnt; i++) begin
      taken[walk] = 1'b1;
      walk = nxt_tbl[walk];
    end
    do s = $urandom_range(POOL_SLOTS - 1); while (taken[s]);
    return s;
  endfunction

  function automatic logic [31:0] pick_qty();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 10) return '0;
    if (k < 20) return '1;
    return $urandom;
  endfunction

  // Offer one request, hold it until the transfer, then record its expected response.
  task automatic send_req(input logic [1:0] op, input int unsigned where,
                          input logic [31:0] qty);
    plq_req_t r;
    r.req_type = op;
    r.slot     = where[SLOT_W-1:0];
    r.quantity = qty;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    level_rsp_q.push_back(level_step(r));
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= (rst_n && !calm) ? ($urandom_range(99) < IDLE_PCT) : 1'b0;
    end
  end

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    plq_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (level_rsp_q.size() == 0) begin
        $error("response transfer with no request outstanding");
        err_cnt++;
      end else begin
        want = level_rsp_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("head_slot", 64'(want.head_slot), 64'(out_data.head_slot));
        check_field("tail_slot", 64'(want.tail_slot), 64'(out_data.tail_slot));
        check_field("count", 64'(want.count), 64'(out_data.count));
        check_field("total_volume", 64'(want.total_volume), 64'(out_data.total_volume));
      end
    end
  end

  task automatic test_empty_list();
    send_req(REQ_REMOVE, 0, 32'h0);
    send_req(REQ_MOVE, 0, 32'h0);
    send_req(REQ_UNUSED, 42, 32'hFFFF_FFFF);
  endtask

  task automatic test_lone_entry();
    send_req(REQ_APPEND, 63, 32'hFFFF_FFFF);
    send_req(REQ_MOVE, 63, 32'h0);
    send_req(REQ_APPEND, 0, 32'h0);
  endtask

  task automatic test_link_moves();
    send_req(REQ_APPEND, 21, 32'h5555_5555);
    send_req(REQ_APPEND, 42, 32'hAAAA_AAAA);
    send_req(REQ_MOVE, 63, 32'h0);
    send_req(REQ_MOVE, 21, 32'h0);
    send_req(REQ_MOVE, 21, 32'hFFFF_FFFF);
  endtask

  task automatic test_removals();
    send_req(REQ_REMOVE, 42, 32'h0);
    send_req(REQ_REMOVE, 21, 32'h0);
    send_req(REQ_REMOVE, 0, 32'h0);
    send_req(REQ_REMOVE, 63, 32'h0);
    send_req(REQ_APPEND, 5, 32'h1);
    send_req(REQ_APPEND, 6, 32'hFFFF_FFFF);
    send_req(REQ_REMOVE, 6, 32'h0);
  endtask

  // Alternate growing and draining phases so the pool fills and empties.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned roll;
    bit grow;
    for (int unsigned i = 0; i < n_items; i++) begin
      grow = ((i / 200) % 2) == 0;
      calm = (i >= 420 && i < 560);
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_req(REQ_UNUSED, $urandom_range(POOL_SLOTS - 1), $urandom);
      end else if (roll < (grow ? 65 : 25)) begin
        if (live_cnt < POOL_SLOTS)
          send_req(REQ_APPEND, pick_free(), pick_qty());
        else
          send_req(REQ_APPEND, $urandom_range(POOL_SLOTS - 1), pick_qty());
      end else if (roll < (grow ? 80 : 78)) begin
        send_req(REQ_REMOVE, (live_cnt != 0) ? pick_listed() : $urandom_range(POOL_SLOTS - 1),
                 $urandom);
      end else begin
        send_req(REQ_MOVE, (live_cnt != 0) ? pick_listed() : $urandom_range(POOL_SLOTS - 1),
                 $urandom);
      end
    end
    calm = 1'b0;
  endtask

  // Requests that ignore list membership; retry any that would read an unwritten entry.
  task automatic test_misuse(input int unsigned n_items);
    plq_req_t r;
    int unsigned tries;
    repeat (n_items) begin
      tries = 0;
      do begin
        r.req_type = 2'($urandom_range(3));
        r.slot     = SLOT_W'($urandom_range(POOL_SLOTS - 1));
        r.quantity = pick_qty();
        tries++;
      end while (!reads_defined(r) && tries < 50);
      if (!reads_defined(r)) r.req_type = REQ_UNUSED;
      send_req(r.req_type, r.slot, r.quantity);
    end
  endtask

  task automatic finish_run();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (level_rsp_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (level_rsp_q.size() != 0) begin
      $error("%0d responses never arrived", level_rsp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_lone_entry();
    test_link_moves();
    test_removals();
    test_random_traffic(1000);
    test_misuse(60);
    finish_run();
  end

endmodule

// ----- filelist.f -----
src/plq_pkg.sv
src/plq_link_mem.sv
src/price_level_order_queue.sv
src/plq_checker.sv
verif/tb_top.sv
